// ===== rtl/core/stbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, command codes and the control/status structs of the
// sorted-table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

   // table geometry
   localparam int unsigned TABLE_DEPTH = 1024;
   localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
   // bounds lo and high+1 run from 0 up to TABLE_DEPTH
   localparam int unsigned BOUND_W     = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned VALUE_W     = 32;

   // stream payload widths
   localparam int unsigned REQ_DATA_W  = 80;
   localparam int unsigned RSP_DATA_W  = 8;

   // request kinds carried in req_tuser
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic start;       // open a search: latch key, set bounds
      logic write;       // store a table entry
      logic probe;       // read the midpoint entry
      logic step;        // narrow the bounds after a miss
      logic push;        // load the result register
      logic push_found;  // value pushed
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic empty;       // search range exhausted
      logic hit;         // probed entry equals key
      logic out_free;    // result register can take a new result
   } dp_status_type;

endpackage

// ===== rtl/core/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a software-loaded table of signed 32-bit entries.
// ----------------------------------------------------------------------------
// Load requests (req_tuser = 0) write one table entry and are taken every
// cycle while no search runs, with no response; loads at an index past the
// table are dropped. Search requests (req_tuser = 1) run a binary search
// over the first entry_count entries (clamped to the table size) and return
// one transfer whose bit 0 is the found flag. Each probe is a registered
// memory read followed by a compare, so a search over 1024 entries takes up
// to 11 probes. A miss after 11 probes ends with the empty-range check and
// then the loading of the output register. The next request can be taken
// in the same cycle that the result appears in the output register; no new
// request is taken while a search runs. While the previous result still
// waits in the output register, the search holds in its last state and the
// input stays stalled. Entries must be loaded before a search can reach
// them. Write csr_wdata only while idle.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
   import stbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] load_index, [41:10] entry_value, [73:42] search_key, [79:74] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command: 0 load, 1 search
   input  logic                  req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] found, [7:1] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // entry_count register
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata
);

   ctrl_cmd_type              cmd;
   dp_status_type             status;
   logic [INDEX_W-1:0]        load_index;
   logic signed [VALUE_W-1:0] entry_value;
   logic signed [VALUE_W-1:0] search_key;
   logic                      rsp_found;

   // unpack the request transfer
   assign load_index  = req_tdata[INDEX_W-1:0];
   assign entry_value = req_tdata[INDEX_W +: VALUE_W];
   assign search_key  = req_tdata[INDEX_W + VALUE_W +: VALUE_W];

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   stbs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .load_index  (load_index),
      .entry_value (entry_value),
      .search_key  (search_key),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_found   (rsp_found)
   );

   // pack the response transfer
   assign rsp_tdata = {{(RSP_DATA_W - 1){1'b0}}, rsp_found};

endmodule

// ===== rtl/core/stbs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, entry count register, search bounds, key and probe compare,
// and the result register.
// ----------------------------------------------------------------------------
module stbs_datapath
   import stbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   input  logic                      csr_we,
   input  logic [COUNT_W-1:0]        csr_wdata,
   input  logic [INDEX_W-1:0]        load_index,
   input  logic signed [VALUE_W-1:0] entry_value,
   input  logic signed [VALUE_W-1:0] search_key,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_found
);

   localparam int unsigned SAT_W = (COUNT_W > BOUND_W) ? COUNT_W : BOUND_W;
   localparam int unsigned IDX_W = (INDEX_W > BOUND_W) ? INDEX_W : BOUND_W;

   logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [BOUND_W-1:0]        lo_ff, lo_in;
   logic [BOUND_W-1:0]        hix_ff, hix_in;   // high bound plus one
   logic [ADDR_W-1:0]         mid_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic signed [VALUE_W-1:0] rd_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      found_ff;

   logic [SAT_W-1:0]          count_wide;
   logic [SAT_W-1:0]          count_sat;
   logic [BOUND_W:0]          mid_sum;
   logic [ADDR_W-1:0]         mid_c;
   logic [IDX_W-1:0]          index_wide;
   logic                      index_ok;

   // clamp the entry count to the table size
   assign count_wide = SAT_W'(count_ff);
   assign count_sat  = (count_wide > SAT_W'(TABLE_DEPTH)) ? SAT_W'(TABLE_DEPTH) : count_wide;

   // midpoint of lo .. hix-1, only used while lo < hix
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hix_ff} - {{BOUND_W{1'b0}}, 1'b1};
   assign mid_c   = mid_sum[ADDR_W:1];

   // drop loads outside the table
   assign index_wide = IDX_W'(load_index);
   assign index_ok   = index_wide < IDX_W'(TABLE_DEPTH);

   assign status.empty    = lo_ff >= hix_ff;
   assign status.hit      = rd_ff == key_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // next values of the control registers
   always_comb begin
      count_in = count_ff;
      if (csr_we) begin
         count_in = csr_wdata;
      end
      lo_in  = lo_ff;
      hix_in = hix_ff;
      if (cmd.start) begin
         lo_in  = '0;
         hix_in = count_sat[BOUND_W-1:0];
      end else if (cmd.step) begin
         if (key_ff > rd_ff) begin
            lo_in = BOUND_W'(mid_ff) + BOUND_W'(1);
         end else begin
            hix_in = BOUND_W'(mid_ff);
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lo_ff        <= '0;
         hix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lo_ff        <= lo_in;
         hix_ff       <= hix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: key, probe address, result
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= search_key;
      end
      if (cmd.probe) begin
         mid_ff <= mid_c;
      end
      if (cmd.push) begin
         found_ff <= cmd.push_found;
      end
   end

   // table memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.write && index_ok) begin
         table_mem[ADDR_W'(index_wide)] <= entry_value;
      end
      if (cmd.probe) begin
         rd_ff <= table_mem[mid_c];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found  = found_ff;

endmodule

// ===== rtl/core/stbs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller for the binary search: takes requests, sequences probe and
// compare steps, and hands the found flag to the result register.
// ----------------------------------------------------------------------------
module stbs_ctrl
   import stbs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_kind,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      found_ff;
   logic      accept;

   assign accept = req_tvalid && ready_ff;

   // decode commands from state and status
   always_comb begin
      cmd            = '0;
      cmd.start      = accept && (req_kind == CMD_SEARCH);
      cmd.write      = accept && (req_kind == CMD_LOAD);
      cmd.probe      = (state_ff == ST_PROBE) && !status.empty;
      cmd.step       = (state_ff == ST_CHECK) && !status.hit;
      cmd.push       = (state_ff == ST_FINISH) && status.out_free;
      cmd.push_found = found_ff;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         found_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_kind == CMD_SEARCH)) begin
                  ready_ff <= 1'b0;
                  state_ff <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               if (status.empty) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (status.hit) begin
                  found_ff <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_PROBE;
               end
            end
            ST_FINISH: begin
               if (status.out_free) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               ready_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = ready_ff;

endmodule
